// File: hdl/i2ctrb_pkg.sv
// ----------------------------------------------------------------------------
// I2C target register bank package
// Types, codes and constants shared by the control, bank and top modules.
// ----------------------------------------------------------------------------
package i2ctrb_pkg;

   // Default number of registers in the bank.
   localparam int BANK_DEPTH_DEFAULT = 16;

   // Widths of the register pointer and the data bytes.
   localparam int PTR_W  = 8;
   localparam int BYTE_W = 8;

   // Phase length codes for the shift register.
   localparam logic [3:0] COUNT_ACK  = 4'd1;
   localparam logic [3:0] COUNT_BYTE = 4'd8;

   // Read/write select bit of the address byte.
   localparam logic [7:0] RW_BIT = 8'h01;

   // Configuration register indexes.
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_BANK_LENGTH = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [6:0] OWN_ADDRESS_RESET = 7'd0;
   localparam logic [4:0] BANK_LENGTH_RESET = 5'd16;

   // Event codes on the request channel.
   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_SHIFT = 2'd2,
      CMD_LOCAL = 2'd3
   } cmd_type;

   // Bus protocol phases.
   typedef enum logic [2:0] {
      PH_ADDR       = 3'd0,
      PH_SEND       = 3'd1,
      PH_SEND_WAIT  = 3'd2,
      PH_SEND_CHECK = 3'd3,
      PH_RECV       = 3'd4,
      PH_RECV_ACK   = 3'd5
   } phase_type;

   // Access to the register bank for one transaction.
   typedef struct packed {
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } mem_req_type;

   // Result fields known before the bank read data returns.
   typedef struct packed {
      logic              drive_sda;
      logic [3:0]        bit_count;
      logic              engaged;
      logic              use_mem;
      logic              reg_write;
      logic [3:0]        reg_index;
      logic [BYTE_W-1:0] reg_value;
   } result_meta_type;

endpackage

// File: hdl/i2c_target_register_bank_top.sv
// A result passes through the read stage and the output register before it can be taken.
// Throughput: one transaction per cycle while rsp_stall is low; the bank is
// read or written at most once per transaction through its single port, read
// data registered. A read stage and an output register let one transaction
// enter while a result waits. Reset clears control state and the bank valid
// bits at once, so the bank reads as zero with no clearing pass.
// ----------------------------------------------------------------------------
// I2C target register bank top level
// Event-level I2C target with address match, register pointer, auto-increment
// reads and notified master writes into a memory-based register bank.
// ----------------------------------------------------------------------------
module i2c_target_register_bank_top #(
   parameter int BANK_DEPTH = i2ctrb_pkg::BANK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_shift_data,
   input  logic [3:0]  req_local_index,
   input  logic [7:0]  req_local_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_drive_sda,
   output logic [7:0]  rsp_tx_byte,
   output logic [3:0]  rsp_bit_count,
   output logic        rsp_engaged,
   output logic        rsp_reg_write,
   output logic [3:0]  rsp_reg_index,
   output logic [7:0]  rsp_reg_value
);

   i2ctrb_pkg::mem_req_type       mem_req;
   i2ctrb_pkg::result_meta_type   meta;
   i2ctrb_pkg::result_meta_type   s1_meta_ff;
   i2ctrb_pkg::result_meta_type   s2_meta_ff;
   logic [7:0]                    rd_byte;
   logic [7:0]                    s2_tx_ff;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s2_valid_ff, s2_valid_in;
   logic                          accept;
   logic                          s1_move;

   // Stage flow: the read stage drains into the output register when it is
   // empty or its result is being taken.
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   i2ctrb_ctrl #(
      .BANK_DEPTH(BANK_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .cmd         (req_cmd),
      .shift_data  (req_shift_data),
      .local_index (req_local_index),
      .local_value (req_local_value),
      .mem_req     (mem_req),
      .meta        (meta)
   );

   i2ctrb_bank #(
      .BANK_DEPTH(BANK_DEPTH)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_byte (rd_byte)
   );

   // Valid bits of the read stage and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
      s2_valid_in = s2_valid_ff;
      if (s2_valid_ff && !rsp_stall) begin
         s2_valid_in = 1'b0;
      end
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers; the transmit byte is resolved from the bank read data.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         s2_meta_ff <= s1_meta_ff;
         s2_tx_ff   <= s1_meta_ff.use_mem ? rd_byte : 8'd0;
      end
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_drive_sda = s2_meta_ff.drive_sda;
   assign rsp_tx_byte   = s2_tx_ff;
   assign rsp_bit_count = s2_meta_ff.bit_count;
   assign rsp_engaged   = s2_meta_ff.engaged;
   assign rsp_reg_write = s2_meta_ff.reg_write;
   assign rsp_reg_index = s2_meta_ff.reg_index;
   assign rsp_reg_value = s2_meta_ff.reg_value;

endmodule

// File: hdl/i2ctrb_bank.sv
// ----------------------------------------------------------------------------
// I2C target register bank storage
// Single-port synchronous memory with a registered read and per-entry
// valid bits, so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module i2ctrb_bank #(
   parameter int BANK_DEPTH = i2ctrb_pkg::BANK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  i2ctrb_pkg::mem_req_type           mem_req,
   output logic [i2ctrb_pkg::BYTE_W-1:0]     rd_byte
);

   localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [i2ctrb_pkg::BYTE_W-1:0] mem [BANK_DEPTH];
   logic [BANK_DEPTH-1:0]         valid_ff;
   logic [BANK_DEPTH-1:0]         valid_in;
   logic [i2ctrb_pkg::BYTE_W-1:0] rdata_ff;
   logic                          rvalid_ff;
   logic [AW-1:0]                 wr_idx;
   logic [AW-1:0]                 rd_idx;

   assign wr_idx = mem_req.wr_addr[AW-1:0];
   assign rd_idx = mem_req.rd_addr[AW-1:0];

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[wr_idx] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rdata_ff  <= mem[rd_idx];
         rvalid_ff <= valid_ff[rd_idx];
      end
   end

   // An entry becomes valid once it has been written.
   always_comb begin
      valid_in = valid_ff;
      if (mem_req.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entries not yet written read as their reset value of zero.
   assign rd_byte = rvalid_ff ? rdata_ff : '0;

endmodule

// File: hdl/i2ctrb_ctrl.sv
// ----------------------------------------------------------------------------
// I2C target register bank control
// Configuration registers, bus phase state machine and register pointer.
// Produces the bank access and the result fields for each transaction.
// ----------------------------------------------------------------------------
module i2ctrb_ctrl #(
   parameter int BANK_DEPTH = i2ctrb_pkg::BANK_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_index,
   input  logic [6:0]                        csr_wdata,
   input  logic                              accept,
   input  logic [1:0]                        cmd,
   input  logic [7:0]                        shift_data,
   input  logic [3:0]                        local_index,
   input  logic [7:0]                        local_value,
   output i2ctrb_pkg::mem_req_type           mem_req,
   output i2ctrb_pkg::result_meta_type       meta
);

   localparam logic [8:0] DEPTH_W = 9'(BANK_DEPTH);

   i2ctrb_pkg::phase_type               phase_ff, phase_in;
   logic                                armed_ff, armed_in;
   logic [i2ctrb_pkg::PTR_W-1:0]        pointer_ff, pointer_in;
   logic                                loaded_ff, loaded_in;
   logic [6:0]                          own_address_ff;
   logic [4:0]                          bank_length_ff;
   logic [8:0]                          limit;
   logic                                ptr_ok;
   logic                                addr_match;
   logic                                local_ok;
   i2ctrb_pkg::cmd_type                 cmd_code;

   assign cmd_code   = i2ctrb_pkg::cmd_type'(cmd);
   assign limit      = (9'(bank_length_ff) < DEPTH_W) ? 9'(bank_length_ff) : DEPTH_W;
   assign ptr_ok     = 9'(pointer_ff) < limit;
   assign addr_match = (shift_data == 8'd0) || (shift_data[7:1] == own_address_ff);
   assign local_ok   = 9'(local_index) < DEPTH_W;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= i2ctrb_pkg::OWN_ADDRESS_RESET;
         bank_length_ff <= i2ctrb_pkg::BANK_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            i2ctrb_pkg::CSR_OWN_ADDRESS: own_address_ff <= csr_wdata;
            i2ctrb_pkg::CSR_BANK_LENGTH: bank_length_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Next state of the bus phase, arming and pointer.
   always_comb begin
      phase_in   = phase_ff;
      armed_in   = armed_ff;
      pointer_in = pointer_ff;
      loaded_in  = loaded_ff;
      if (accept) begin
         case (cmd_code)
            i2ctrb_pkg::CMD_START: begin
               phase_in = i2ctrb_pkg::PH_ADDR;
               armed_in = 1'b1;
            end
            i2ctrb_pkg::CMD_STOP: begin
               phase_in = i2ctrb_pkg::PH_ADDR;
               armed_in = 1'b0;
            end
            i2ctrb_pkg::CMD_SHIFT: begin
               if (armed_ff) begin
                  case (phase_ff)
                     i2ctrb_pkg::PH_ADDR: begin
                        if (addr_match) begin
                           if ((shift_data & i2ctrb_pkg::RW_BIT) != 8'd0) begin
                              phase_in = i2ctrb_pkg::PH_SEND;
                           end else begin
                              phase_in  = i2ctrb_pkg::PH_RECV;
                              loaded_in = 1'b0;
                           end
                        end else begin
                           armed_in = 1'b0;
                        end
                     end
                     i2ctrb_pkg::PH_SEND: begin
                        phase_in = i2ctrb_pkg::PH_SEND_WAIT;
                        if (ptr_ok) begin
                           pointer_in = pointer_ff + 8'd1;
                        end
                     end
                     i2ctrb_pkg::PH_SEND_WAIT: begin
                        phase_in = i2ctrb_pkg::PH_SEND_CHECK;
                     end
                     i2ctrb_pkg::PH_SEND_CHECK: begin
                        if (shift_data != 8'd0) begin
                           armed_in = 1'b0;
                           phase_in = i2ctrb_pkg::PH_ADDR;
                        end else begin
                           phase_in = i2ctrb_pkg::PH_SEND_WAIT;
                           if (ptr_ok) begin
                              pointer_in = pointer_ff + 8'd1;
                           end
                        end
                     end
                     i2ctrb_pkg::PH_RECV: begin
                        phase_in = i2ctrb_pkg::PH_RECV_ACK;
                     end
                     i2ctrb_pkg::PH_RECV_ACK: begin
                        phase_in = i2ctrb_pkg::PH_RECV;
                        if (!loaded_ff) begin
                           pointer_in = shift_data;
                           loaded_in  = 1'b1;
                        end
                     end
                     default: begin
                        armed_in = 1'b0;
                        phase_in = i2ctrb_pkg::PH_ADDR;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // Result fields and bank access for the current transaction.
   always_comb begin
      meta              = '0;
      meta.bit_count    = i2ctrb_pkg::COUNT_BYTE;
      meta.engaged      = armed_in;
      mem_req           = '0;
      mem_req.rd_addr   = pointer_ff;
      mem_req.wr_addr   = pointer_ff;
      mem_req.wr_data   = shift_data;
      if (accept) begin
         case (cmd_code)
            i2ctrb_pkg::CMD_LOCAL: begin
               mem_req.wr_en   = local_ok;
               mem_req.wr_addr = 8'(local_index);
               mem_req.wr_data = local_value;
            end
            i2ctrb_pkg::CMD_SHIFT: begin
               if (armed_ff) begin
                  case (phase_ff)
                     i2ctrb_pkg::PH_ADDR: begin
                        if (addr_match) begin
                           meta.drive_sda = 1'b1;
                           meta.bit_count = i2ctrb_pkg::COUNT_ACK;
                        end
                     end
                     i2ctrb_pkg::PH_SEND: begin
                        meta.drive_sda = 1'b1;
                        meta.use_mem   = ptr_ok;
                        mem_req.rd_en  = ptr_ok;
                     end
                     i2ctrb_pkg::PH_SEND_WAIT: begin
                        meta.bit_count = i2ctrb_pkg::COUNT_ACK;
                     end
                     i2ctrb_pkg::PH_SEND_CHECK: begin
                        if (shift_data == 8'd0) begin
                           meta.drive_sda = 1'b1;
                           meta.use_mem   = ptr_ok;
                           mem_req.rd_en  = ptr_ok;
                        end
                     end
                     i2ctrb_pkg::PH_RECV_ACK: begin
                        meta.drive_sda = 1'b1;
                        meta.bit_count = i2ctrb_pkg::COUNT_ACK;
                        if (loaded_ff && ptr_ok) begin
                           mem_req.wr_en  = 1'b1;
                           meta.reg_write = 1'b1;
                           meta.reg_index = pointer_ff[3:0];
                           meta.reg_value = shift_data;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= i2ctrb_pkg::PH_ADDR;
         armed_ff   <= 1'b0;
         pointer_ff <= '0;
         loaded_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         armed_ff   <= armed_in;
         pointer_ff <= pointer_in;
         loaded_ff  <= loaded_in;
      end
   end

endmodule
